@@ sv/rmu_pkg.sv @@
// Package with the shared types and constants of the recursive mutex unit.
`default_nettype none

package rmu_pkg;

	// Fixed field widths of the request and response items.
	localparam int ID_W     = 4;
	localparam int MASK_W   = 16;
	localparam int STATUS_W = 3;
	localparam int ID_REACH = 1 << ID_W;

	// Default sizes of the mutex bank.
	localparam int DEF_MUTEX_COUNT   = 16;
	localparam int DEF_PROCESS_COUNT = 16;
	localparam int DEF_COUNT_BITS    = 8;

	// Requested operation.
	typedef enum logic {
		OP_LOCK   = 1'b0,
		OP_UNLOCK = 1'b1
	} rmu_op_t;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_BLOCKED   = 3'd1,
		ST_RELOCK    = 3'd2,
		ST_NOT_OWNER = 3'd3,
		ST_OVERFLOW  = 3'd4
	} rmu_status_t;

	// One request item as held in the input stage.
	typedef struct packed {
		rmu_op_t         op;
		logic [ID_W-1:0] process_id;
		logic [ID_W-1:0] mutex_id;
	} rmu_item_t;

	// One response item.
	typedef struct packed {
		rmu_status_t     status;
		logic            woken_valid;
		logic [ID_W-1:0] woken_process;
	} rmu_result_t;

endpackage

`default_nettype wire

@@ sv/rmu_if.sv @@
// Valid/ready channel interfaces for the request and response items.
`default_nettype none

interface rmu_req_if;
	logic                     valid;
	logic                     ready;
	logic                     op;
	logic [rmu_pkg::ID_W-1:0] process_id;
	logic [rmu_pkg::ID_W-1:0] mutex_id;

	modport source (output valid, output op, output process_id, output mutex_id,
		input ready);
	modport sink (input valid, input op, input process_id, input mutex_id,
		output ready);
endinterface

interface rmu_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [rmu_pkg::STATUS_W-1:0] status;
	logic                         woken_valid;
	logic [rmu_pkg::ID_W-1:0]     woken_process;

	modport source (output valid, output status, output woken_valid,
		output woken_process, input ready);
	modport sink (input valid, input status, input woken_valid,
		input woken_process, output ready);
endinterface

`default_nettype wire

@@ sv/recursive_mutex_unit.sv @@
// Top level of the recursive mutex unit: input stage, state table and response register.
//
// Usage: a bank of mutexes with per-mutex FIFO wait queues. Each request item on
// the req channel (valid/ready) asks to lock or unlock one mutex for one process;
// each request yields exactly one response item on the rsp channel, carrying the
// status and, for a final unlock with waiters, the process taken from the queue.
// A woken process must send its lock request again.
// The recursive mask is written through cfg_we/cfg_data, by the user only while no request
// is in flight, which the block itself does not enforce; bit m set makes mutex m recursive.
// A request goes from the input register through the table into the response register.
// Throughput: one item per cycle while rsp.ready is high, set by the single
// read-modify-write of the table between the input register and the response register.
// Reset (arst_n low) frees every mutex, empties every queue, clears the mask and
// drops both stages. When the receiver holds rsp.ready low, the response stays in
// its register, one more request is held in the input stage, and req.ready then
// falls until the response is taken.
`default_nettype none

module recursive_mutex_unit #(
	parameter int MUTEX_COUNT   = rmu_pkg::DEF_MUTEX_COUNT,
	parameter int PROCESS_COUNT = rmu_pkg::DEF_PROCESS_COUNT,
	parameter int COUNT_BITS    = rmu_pkg::DEF_COUNT_BITS
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	rmu_req_if.sink                         req,
	rmu_rsp_if.source                       rsp,
	input  wire logic                       cfg_we,
	input  wire logic [rmu_pkg::MASK_W-1:0] cfg_data
);
	import rmu_pkg::*;

	logic                vld_s1;
	rmu_item_t           item_s1;
	logic                rsp_vld_q;
	rmu_result_t         result_q;
	rmu_result_t         result;
	logic [MASK_W-1:0]   mask_q;
	logic                advance;
	logic                accept;

	// The input stage moves on when the response register is free or being emptied.
	assign advance   = vld_s1 && (!rsp_vld_q || rsp.ready);
	assign req.ready = !vld_s1 || advance;
	assign accept    = req.valid && req.ready;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (cfg_we) begin
			mask_q <= cfg_data;
		end
	end

	// Input stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept || (vld_s1 && !advance);
		end
	end

	// Input stage payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.op         <= rmu_op_t'(req.op);
			item_s1.process_id <= req.process_id;
			item_s1.mutex_id   <= req.mutex_id;
		end
	end

	rmu_table #(
		.MUTEX_COUNT   (MUTEX_COUNT),
		.PROCESS_COUNT (PROCESS_COUNT),
		.COUNT_BITS    (COUNT_BITS)
	) u_table (
		.clk            (clk),
		.arst_n         (arst_n),
		.commit         (advance),
		.item           (item_s1),
		.recursive_mask (mask_q),
		.result         (result)
	);

	// Response register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else begin
			rsp_vld_q <= advance || (rsp_vld_q && !rsp.ready);
		end
	end

	// Response register payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

	assign rsp.valid         = rsp_vld_q;
	assign rsp.status        = result_q.status;
	assign rsp.woken_valid   = result_q.woken_valid;
	assign rsp.woken_process = result_q.woken_process;

endmodule

`default_nettype wire

@@ sv/rmu_table.sv @@
// Mutex state table: owner, hold count and FIFO wait queues, updated once per item.
`default_nettype none

module rmu_table #(
	parameter int MUTEX_COUNT   = rmu_pkg::DEF_MUTEX_COUNT,
	parameter int PROCESS_COUNT = rmu_pkg::DEF_PROCESS_COUNT,
	parameter int COUNT_BITS    = rmu_pkg::DEF_COUNT_BITS
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         commit,
	input  wire rmu_pkg::rmu_item_t           item,
	input  wire logic [rmu_pkg::MASK_W-1:0]   recursive_mask,
	output rmu_pkg::rmu_result_t              result
);
	import rmu_pkg::*;

	// Only ids that fit the id fields can ever be addressed.
	localparam int MSTORE = (MUTEX_COUNT < ID_REACH) ? MUTEX_COUNT : ID_REACH;
	localparam int PSTORE = (PROCESS_COUNT < ID_REACH) ? PROCESS_COUNT : ID_REACH;
	localparam int MIDX_W = $clog2(MSTORE);
	localparam int PIDX_W = $clog2(PSTORE);
	localparam int CMP_W  = 8;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

	// Per-mutex state.
	logic [COUNT_BITS-1:0] hold_q      [MSTORE];
	logic [ID_W-1:0]       owner_q     [MSTORE];
	logic                  owner_vld_q [MSTORE];
	logic [ID_W-1:0]       head_q      [MSTORE];
	logic [ID_W-1:0]       tail_q      [MSTORE];
	logic                  queued_q    [MSTORE];
	// Per-process state.
	logic [ID_W-1:0]       next_q      [PSTORE];
	logic                  waiting_q   [PSTORE];

	logic [MIDX_W-1:0]     mi;
	logic [PIDX_W-1:0]     pi;
	logic [PIDX_W-1:0]     hi;
	logic [PIDX_W-1:0]     ti;
	logic                  in_range;
	logic [COUNT_BITS-1:0] cur_count;
	logic                  cur_vld;
	logic                  is_owner;
	logic                  is_rec;

	logic                  upd_own;
	logic                  new_vld;
	logic [ID_W-1:0]       new_owner;
	logic [COUNT_BITS-1:0] new_count;
	logic                  do_enq;
	logic                  do_deq;
	logic                  deq_last;

	// Read the addressed entries.
	always_comb begin
		mi        = item.mutex_id[MIDX_W-1:0];
		pi        = item.process_id[PIDX_W-1:0];
		hi        = head_q[mi][PIDX_W-1:0];
		ti        = tail_q[mi][PIDX_W-1:0];
		in_range  = (CMP_W'(item.mutex_id) < CMP_W'(MUTEX_COUNT)) &&
			(CMP_W'(item.process_id) < CMP_W'(PROCESS_COUNT));
		cur_count = hold_q[mi];
		cur_vld   = owner_vld_q[mi];
		is_owner  = cur_vld && (owner_q[mi] == item.process_id);
		is_rec    = recursive_mask[item.mutex_id];
	end

	// Decide the outcome and the state updates for the current item.
	always_comb begin
		result.status        = ST_OK;
		result.woken_valid   = 1'b0;
		result.woken_process = '0;
		upd_own   = 1'b0;
		new_vld   = cur_vld;
		new_owner = owner_q[mi];
		new_count = cur_count;
		do_enq    = 1'b0;
		do_deq    = 1'b0;
		deq_last  = (tail_q[mi] == head_q[mi]);
		if (!in_range) begin
			result.status = ST_NOT_OWNER;
		end else if (item.op == OP_LOCK) begin
			if (!cur_vld) begin
				upd_own   = 1'b1;
				new_vld   = 1'b1;
				new_owner = item.process_id;
				new_count = COUNT_ONE;
			end else if (is_owner) begin
				if (!is_rec) begin
					result.status = ST_RELOCK;
				end else if (cur_count == COUNT_MAX) begin
					result.status = ST_OVERFLOW;
				end else begin
					upd_own   = 1'b1;
					new_count = cur_count + COUNT_ONE;
				end
			end else begin
				result.status = ST_BLOCKED;
				do_enq        = !waiting_q[pi];
			end
		end else begin
			if (!is_owner) begin
				result.status = ST_NOT_OWNER;
			end else begin
				upd_own   = 1'b1;
				new_count = cur_count - COUNT_ONE;
				// Last release frees the mutex and wakes the head waiter.
				if (cur_count == COUNT_ONE) begin
					new_vld   = 1'b0;
					new_owner = '0;
					if (queued_q[mi]) begin
						do_deq               = 1'b1;
						result.woken_valid   = 1'b1;
						result.woken_process = head_q[mi];
					end
				end
			end
		end
	end

	// State that reset clears.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MSTORE; i++) begin
				hold_q[i]      <= '0;
				owner_q[i]     <= '0;
				owner_vld_q[i] <= 1'b0;
				queued_q[i]    <= 1'b0;
			end
			for (int i = 0; i < PSTORE; i++) begin
				waiting_q[i] <= 1'b0;
			end
		end else if (commit) begin
			if (upd_own) begin
				hold_q[mi]      <= new_count;
				owner_q[mi]     <= new_owner;
				owner_vld_q[mi] <= new_vld;
			end
			if (do_enq) begin
				queued_q[mi]  <= 1'b1;
				waiting_q[pi] <= 1'b1;
			end
			if (do_deq) begin
				if (deq_last) begin
					queued_q[mi] <= 1'b0;
				end
				waiting_q[hi] <= 1'b0;
			end
		end
	end

	// Queue links, meaningful only once written.
	always_ff @(posedge clk) begin
		if (commit) begin
			if (do_enq) begin
				if (queued_q[mi]) begin
					next_q[ti] <= item.process_id;
				end else begin
					head_q[mi] <= item.process_id;
				end
				tail_q[mi] <= item.process_id;
			end
			if (do_deq && !deq_last) begin
				head_q[mi] <= next_q[hi];
			end
		end
	end

endmodule

`default_nettype wire

@@ bench/tb_recursive_mutex_unit.sv @@
// Self-checking testbench for the recursive mutex unit: directed table, saturation, random traffic.
module tb_recursive_mutex_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import rmu_pkg::*;

	localparam int NMUTEX = DEF_MUTEX_COUNT;
	localparam int NPROC  = DEF_PROCESS_COUNT;
	localparam int CNT_W  = DEF_COUNT_BITS;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;
	localparam int ROWS = 23;

	// One row of the directed table; the expected fields count only where typed is set.
	typedef struct packed {
		rmu_op_t          op;
		logic [ID_W-1:0]  pid;
		logic [ID_W-1:0]  mid;
		logic             typed;
		rmu_status_t      st;
		logic             wv;
		logic [ID_W-1:0]  wp;
	} plan_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [MASK_W-1:0] cfg_data;

	rmu_req_if req_ch();
	rmu_rsp_if rsp_ch();

	recursive_mutex_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.rsp      (rsp_ch),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	// Mirror of the mutex bank, updated as each request item is accepted.
	logic [MASK_W-1:0] recur_mask;
	logic [CNT_W-1:0]  hold_depth [NMUTEX];
	logic [ID_W-1:0]   holder     [NMUTEX];
	logic              held       [NMUTEX];
	logic [ID_W-1:0]   wq_head    [NMUTEX];
	logic [ID_W-1:0]   wq_tail    [NMUTEX];
	logic              wq_busy    [NMUTEX];
	logic [ID_W-1:0]   link_next  [NPROC];
	logic              parked     [NPROC];

	rmu_result_t pending_results [$];
	rmu_item_t   woken_retry_q   [$];
	int          fails;
	bit          calm;

	// Directed table: first rows run with the mask at its reset value of zero.
	plan_row_t plan_rows [ROWS] = '{
		'{OP_LOCK,   4'd0,  4'd0,  1'b1, ST_OK,        1'b0, 4'd0},
		'{OP_LOCK,   4'd0,  4'd0,  1'b1, ST_RELOCK,    1'b0, 4'd0},
		'{OP_UNLOCK, 4'd15, 4'd15, 1'b1, ST_NOT_OWNER, 1'b0, 4'd0},
		'{OP_LOCK,   4'd15, 4'd15, 1'b1, ST_OK,        1'b0, 4'd0},
		'{OP_UNLOCK, 4'd0,  4'd15, 1'b1, ST_NOT_OWNER, 1'b0, 4'd0},
		'{OP_LOCK,   4'd3,  4'd0,  1'b1, ST_BLOCKED,   1'b0, 4'd0},
		'{OP_LOCK,   4'd5,  4'd0,  1'b1, ST_BLOCKED,   1'b0, 4'd0},
		'{OP_LOCK,   4'd3,  4'd15, 1'b1, ST_BLOCKED,   1'b0, 4'd0},
		'{OP_UNLOCK, 4'd0,  4'd0,  1'b1, ST_OK,        1'b1, 4'd3},
		'{OP_LOCK,   4'd9,  4'd0,  1'b1, ST_OK,        1'b0, 4'd0},
		'{OP_UNLOCK, 4'd9,  4'd0,  1'b1, ST_OK,        1'b1, 4'd5},
		'{OP_UNLOCK, 4'd15, 4'd15, 1'b1, ST_OK,        1'b0, 4'd0},
		'{OP_LOCK,   4'd10, 4'd7,  1'b0, ST_OK,        1'b0, 4'd0},
		'{OP_LOCK,   4'd11, 4'd7,  1'b0, ST_OK,        1'b0, 4'd0},
		'{OP_LOCK,   4'd12, 4'd7,  1'b0, ST_OK,        1'b0, 4'd0},
		'{OP_LOCK,   4'd11, 4'd8,  1'b0, ST_OK,        1'b0, 4'd0},
		'{OP_UNLOCK, 4'd10, 4'd7,  1'b0, ST_OK,        1'b0, 4'd0},
		'{OP_UNLOCK, 4'd11, 4'd8,  1'b0, ST_OK,        1'b0, 4'd0},
		'{OP_LOCK,   4'd11, 4'd7,  1'b0, ST_OK,        1'b0, 4'd0},
		'{OP_UNLOCK, 4'd12, 4'd7,  1'b0, ST_OK,        1'b0, 4'd0},
		'{OP_UNLOCK, 4'd11, 4'd7,  1'b0, ST_OK,        1'b0, 4'd0},
		'{OP_LOCK,   4'd12, 4'd7,  1'b0, ST_OK,        1'b0, 4'd0},
		'{OP_UNLOCK, 4'd12, 4'd7,  1'b0, ST_OK,        1'b0, 4'd0}
	};

	// Clock generation.
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Compute the result of one lock or unlock and update the mirrored bank.
	function automatic rmu_result_t mutex_bank_step(input rmu_item_t it);
		rmu_result_t r;
		logic [ID_W-1:0] p;
		logic [ID_W-1:0] m;
		logic [ID_W-1:0] h;
		p = it.process_id;
		m = it.mutex_id;
		r.status = ST_OK;
		r.woken_valid = 1'b0;
		r.woken_process = '0;
		if (it.op == OP_LOCK) begin
			if (!held[m]) begin
				held[m] = 1'b1;
				holder[m] = p;
				hold_depth[m] = CNT_W'(1);
			end else if (holder[m] == p) begin
				if (!recur_mask[m])
					r.status = ST_RELOCK;
				else if (hold_depth[m] == CNT_MAX)
					r.status = ST_OVERFLOW;
				else
					hold_depth[m] = hold_depth[m] + 1'b1;
			end else begin
				// Another process holds it: queue the requester once.
				r.status = ST_BLOCKED;
				if (!parked[p]) begin
					if (wq_busy[m])
						link_next[wq_tail[m]] = p;
					else
						wq_head[m] = p;
					wq_tail[m] = p;
					wq_busy[m] = 1'b1;
					parked[p] = 1'b1;
				end
			end
		end else if (!held[m] || holder[m] != p) begin
			r.status = ST_NOT_OWNER;
		end else begin
			hold_depth[m] = hold_depth[m] - 1'b1;
			if (hold_depth[m] == 0) begin
				// Last release: free the mutex and wake the head waiter.
				held[m] = 1'b0;
				holder[m] = '0;
				if (wq_busy[m]) begin
					h = wq_head[m];
					if (wq_tail[m] == h)
						wq_busy[m] = 1'b0;
					else
						wq_head[m] = link_next[h];
					parked[h] = 1'b0;
					r.woken_valid = 1'b1;
					r.woken_process = h;
				end
			end
		end
		return r;
	endfunction

	// Pick a random item, mostly sensible traffic built on the mirrored state.
	function automatic rmu_item_t pick_item();
		rmu_item_t it;
		int unsigned roll;
		int unsigned base;
		logic [ID_W-1:0] m;
		roll = $urandom_range(0, 99);
		it.op = OP_LOCK;
		it.process_id = 4'($urandom_range(0, NPROC - 1));
		if ($urandom_range(0, 9) < 7)
			it.mutex_id = 4'($urandom_range(0, 3));
		else
			it.mutex_id = 4'($urandom_range(0, NMUTEX - 1));
		if (roll < 30 && woken_retry_q.size() > 0) begin
			it = woken_retry_q.pop_front();
		end else if (roll < 65) begin
			// Unlock by the owner of some held mutex, if there is one.
			base = $urandom_range(0, NMUTEX - 1);
			for (int k = 0; k < NMUTEX; k++) begin
				m = 4'((base + k) % NMUTEX);
				if (held[m] && it.op == OP_LOCK) begin
					it.op = OP_UNLOCK;
					it.mutex_id = m;
					it.process_id = holder[m];
				end
			end
		end else if (roll < 92) begin
			// Lock, now and then a relock by the current owner.
			if (held[it.mutex_id] && $urandom_range(0, 9) < 3)
				it.process_id = holder[it.mutex_id];
		end else begin
			it.op = rmu_op_t'($urandom_range(0, 1));
			it.mutex_id = 4'($urandom_range(0, NMUTEX - 1));
		end
		return it;
	endfunction

	// Offer one item, wait for its acceptance and record what it should produce.
	task automatic send_item(input rmu_item_t it, input bit typed, input rmu_result_t want);
		rmu_result_t pred;
		int gap;
		if (!calm && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 3);
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.op <= it.op;
		req_ch.process_id <= it.process_id;
		req_ch.mutex_id <= it.mutex_id;
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
		pred = mutex_bank_step(it);
		pending_results.push_back(typed ? want : pred);
		if (pred.woken_valid)
			woken_retry_q.push_back('{OP_LOCK, pred.woken_process, it.mutex_id});
	endtask

	// Let the unit go idle, then write the recursive mask.
	task automatic write_mask(input logic [MASK_W-1:0] v);
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		recur_mask = v;
	endtask

	task automatic run_random(input int count);
		for (int k = 0; k < count; k++)
			send_item(pick_item(), 1'b0, '0);
	endtask

	// Response side: random stall bursts, none in the calm tail.
	initial begin : rsp_pacing
		int n;
		rsp_ch.ready = 1'b1;
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 3);
				rsp_ch.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
		end
	end

	// Compare each accepted result item with the oldest expectation.
	always @(posedge clk) begin : rsp_check
		rmu_result_t w;
		if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				$error("result item with no request outstanding");
				fails++;
			end else begin
				w = pending_results.pop_front();
				if (rsp_ch.status !== w.status) begin
					$error("status: expected %0d, got %0d", w.status, rsp_ch.status);
					fails++;
				end
				if (rsp_ch.woken_valid !== w.woken_valid) begin
					$error("woken_valid: expected %0d, got %0d", w.woken_valid,
						rsp_ch.woken_valid);
					fails++;
				end
				if (rsp_ch.woken_process !== w.woken_process) begin
					$error("woken_process: expected %0d, got %0d", w.woken_process,
						rsp_ch.woken_process);
					fails++;
				end
			end
		end
	end

	// Main stimulus sequence.
	initial begin : stimulus
		rmu_item_t it;
		rmu_result_t want;
		logic [ID_W-1:0] sat_pid;
		int n;
		fails = 0;
		calm = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.op = 1'b0;
		req_ch.process_id = '0;
		req_ch.mutex_id = '0;
		recur_mask = '0;
		for (int k = 0; k < NMUTEX; k++) begin
			hold_depth[k] = '0;
			holder[k] = '0;
			held[k] = 1'b0;
			wq_head[k] = '0;
			wq_tail[k] = '0;
			wq_busy[k] = 1'b0;
		end
		for (int k = 0; k < NPROC; k++) begin
			link_next[k] = '0;
			parked[k] = 1'b0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table under the reset mask.
		for (int r = 0; r < ROWS; r++) begin
			it = '{plan_rows[r].op, plan_rows[r].pid, plan_rows[r].mid};
			want = '{plan_rows[r].st, plan_rows[r].wv, plan_rows[r].wp};
			send_item(it, plan_rows[r].typed, want);
		end

		// Drive the top mutex through its full hold count and past it, then back to free.
		write_mask(16'hFFFF);
		sat_pid = held[NMUTEX-1] ? holder[NMUTEX-1] : 4'(NPROC - 1);
		for (int k = 0; k < 258; k++)
			send_item('{OP_LOCK, sat_pid, 4'(NMUTEX - 1)}, 1'b0, '0);
		for (int k = 0; k < 257; k++)
			send_item('{OP_UNLOCK, sat_pid, 4'(NMUTEX - 1)}, 1'b0, '0);

		// Random traffic under several masks.
		write_mask(16'h0000);
		run_random(100);
		write_mask(16'($urandom));
		run_random(100);
		write_mask(16'hFFFF);
		run_random(80);
		calm = 1'b1;
		run_random(80);
		req_ch.valid <= 1'b0;

		// Wait for the last result items to drain.
		n = 0;
		while (pending_results.size() != 0 && n < 5000) begin
			@(posedge clk);
			n++;
		end
		repeat (4) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d expected result items never arrived", pending_results.size());
			fails++;
		end
		if (fails == 0)
			$display("tb_recursive_mutex_unit: PASS");
		else
			$display("tb_recursive_mutex_unit: FAIL");
		$finish;
	end

	// Hard stop in case the handshake hangs.
	initial begin : watchdog
		#(3_000_000);
		$display("tb_recursive_mutex_unit: FAIL");
		$finish;
	end

endmodule

@@ sim.f @@
sv/rmu_pkg.sv
sv/rmu_if.sv
sv/rmu_table.sv
sv/recursive_mutex_unit.sv
bench/tb_recursive_mutex_unit.sv
